>>> rtl/core/ldfw_pkg.sv
// Package for the diagonal fade wave block: colour type, command codes and
// reset constants. No dependencies.
package ldfw_pkg;

  // Default grid edge length
  localparam int GRID_DEFAULT = 10;

  // Frame-per-row register
  localparam int FPR_W = 6;
  localparam logic [FPR_W-1:0] FPR_RESET = 6'd20;

  // Item command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // 24-bit LED colour
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam rgb_t RESET_COLOUR = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
  localparam rgb_t BLACK        = '{red: 8'h00, green: 8'h00, blue: 8'h00};

endpackage

>>> rtl/core/ldfw_step.sv
// Colour stepper shared by every cell of a sweep: moves each channel one
// unit toward the target. Depends on ldfw_pkg.
module ldfw_step (
  input  ldfw_pkg::rgb_t cur_i,
  input  ldfw_pkg::rgb_t tgt_i,
  output ldfw_pkg::rgb_t nxt_o,
  output logic           match_o
);

  // One channel: up, down or hold
  function automatic logic [7:0] chan_step(input logic [7:0] cur, input logic [7:0] tgt);
    logic [7:0] res;
    if (cur < tgt) begin
      res = cur + 8'd1;
    end else if (cur > tgt) begin
      res = cur - 8'd1;
    end else begin
      res = cur;
    end
    return res;
  endfunction

  assign nxt_o.red   = chan_step(cur_i.red,   tgt_i.red);
  assign nxt_o.green = chan_step(cur_i.green, tgt_i.green);
  assign nxt_o.blue  = chan_step(cur_i.blue,  tgt_i.blue);

  // Stepped colour equals the target
  assign match_o = (nxt_o == tgt_i);

endmodule

>>> rtl/core/led_matrix_diagonal_fade_wave.sv
// Top level of the diagonal fade wave block: sequencer, LED colour memory
// and wave state. Depends on ldfw_pkg and ldfw_step.
//
// Each accepted item (start high while busy low) gives exactly one result,
// shown for one cycle with out_valid high; the receiver cannot stall, so it
// must take every result as it appears. A start, an ignored code or a frame
// tick with no wave running gives its result in the next cycle. A read
// passes through the registered memory read and the S_READ state before its
// result is registered. A frame tick during a wave sweeps all GRID*GRID
// cells through the single write port of the colour memory and the one
// colour stepper, one cell per cycle, then closes in S_FINISH, where the
// last write-back lands. After reset a clearing pass loads every LED with
// red; busy is high meanwhile, and configuration writes are taken at any
// time.
module led_matrix_diagonal_fade_wave #(
  parameter int GRID = ldfw_pkg::GRID_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Command channel
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_command,
  input  logic [7:0]                 in_target_red,
  input  logic [7:0]                 in_target_green,
  input  logic [7:0]                 in_target_blue,
  input  logic [3:0]                 in_read_x,
  input  logic [3:0]                 in_read_y,
  // Result channel
  output logic                       out_valid,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue,
  output logic                       out_busy_res,
  output logic                       out_finished,
  // Configuration
  input  logic                       cfg_we,
  input  logic [ldfw_pkg::FPR_W-1:0] cfg_data
);

  localparam int NCELL = GRID * GRID;
  localparam int AW    = $clog2(NCELL);
  localparam int XW    = $clog2(GRID);
  localparam int FW    = $clog2(2 * GRID + 1);
  localparam int TW    = ldfw_pkg::FPR_W;

  localparam logic [AW-1:0] ADDR_LAST = AW'(NCELL - 1);
  localparam logic [XW-1:0] X_LAST    = XW'(GRID - 1);
  localparam logic [FW-1:0] FRONT_MAX = FW'(2 * GRID);

  // Sequencer states
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Wave state
  ldfw_pkg::rgb_t   target_r, target_nxt;
  logic [FW-1:0]    front_r, front_nxt;
  logic [TW-1:0]    tick_r, tick_nxt;
  logic             running_r, running_nxt;
  logic             corner_r, corner_nxt;
  logic [TW-1:0]    fpr_r;

  // Sweep counters
  logic [AW-1:0]    k_r, k_nxt;
  logic [XW-1:0]    x_r, x_nxt;
  logic [XW-1:0]    y_r, y_nxt;

  // Write stage of the sweep pipeline
  logic             p_valid_r, p_valid_nxt;
  logic [AW-1:0]    p_addr_r;
  logic             p_lit_r;
  logic             p_corner_r;

  // Read flag for a read item
  logic             rd_inr_r;

  // Result registers
  logic             out_valid_r, out_valid_nxt;
  ldfw_pkg::rgb_t   out_col_r, out_col_nxt;
  logic             out_busy_r, out_busy_nxt;
  logic             out_fin_r, out_fin_nxt;

  // Memory
  ldfw_pkg::rgb_t   mem [NCELL];
  ldfw_pkg::rgb_t   rdata_r;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  ldfw_pkg::rgb_t   wr_data;

  // Stepper
  ldfw_pkg::rgb_t   step_col;
  logic             step_match;

  logic             accept;
  logic             in_range;
  logic [AW-1:0]    in_addr;
  logic             corner_eff;
  logic [TW:0]      tick_sum;
  logic [TW:0]      tick_limit;

  ldfw_step u_step (
    .cur_i   (rdata_r),
    .tgt_i   (target_r),
    .nxt_o   (step_col),
    .match_o (step_match)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Read address of a read item, forced to cell 0 when off the grid
  assign in_range = (32'(in_read_x) < GRID) && (32'(in_read_y) < GRID);
  assign in_addr  = in_range ? AW'(32'(in_read_x) * GRID + 32'(in_read_y)) : '0;
  assign rd_addr  = (state_r == S_SWEEP) ? k_r : in_addr;

  // Single write port: clearing pass or sweep write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_addr_r;
    wr_data = step_col;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = k_r;
      wr_data = ldfw_pkg::RESET_COLOUR;
    end else if (p_valid_r && p_lit_r) begin
      wr_en = 1'b1;
    end
  end

  // Colour memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Corner match including the cell being written this cycle
  assign corner_eff = (p_valid_r && p_lit_r && p_corner_r) ? step_match : corner_r;
  assign tick_sum   = {1'b0, tick_r} + {{TW{1'b0}}, 1'b1};
  assign tick_limit = (fpr_r == '0) ? {{TW{1'b0}}, 1'b1} : {1'b0, fpr_r};

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    front_nxt     = front_r;
    tick_nxt      = tick_r;
    running_nxt   = running_r;
    corner_nxt    = corner_r;
    k_nxt         = k_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    p_valid_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    out_col_nxt   = ldfw_pkg::BLACK;
    out_busy_nxt  = running_r;
    out_fin_nxt   = 1'b0;

    // Corner result lands with the write-back
    if (p_valid_r && p_lit_r && p_corner_r) begin
      corner_nxt = step_match;
    end

    unique case (state_r)
      S_CLEAR: begin
        k_nxt = k_r + AW'(1);
        if (k_r == ADDR_LAST) begin
          k_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            ldfw_pkg::CMD_START: begin
              if (!running_r) begin
                target_nxt  = '{red: in_target_red, green: in_target_green,
                                blue: in_target_blue};
                front_nxt   = FW'(1);
                tick_nxt    = '0;
                corner_nxt  = 1'b0;
                running_nxt = 1'b1;
              end
              out_valid_nxt = 1'b1;
              out_busy_nxt  = 1'b1;
            end
            ldfw_pkg::CMD_TICK: begin
              if (running_r) begin
                k_nxt     = '0;
                x_nxt     = '0;
                y_nxt     = '0;
                state_nxt = S_SWEEP;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ldfw_pkg::CMD_READ: begin
              state_nxt = S_READ;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_col_nxt   = rd_inr_r ? rdata_r : ldfw_pkg::BLACK;
        state_nxt     = S_IDLE;
      end
      S_SWEEP: begin
        // Issue one cell read per cycle
        p_valid_nxt = 1'b1;
        k_nxt       = k_r + AW'(1);
        if (y_r == X_LAST) begin
          y_nxt = '0;
          x_nxt = x_r + XW'(1);
        end else begin
          y_nxt = y_r + XW'(1);
        end
        if (k_r == ADDR_LAST) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // Last write-back and period bookkeeping
        out_valid_nxt = 1'b1;
        if (tick_sum >= tick_limit) begin
          tick_nxt = '0;
          if (corner_eff) begin
            running_nxt = 1'b0;
            out_fin_nxt = 1'b1;
          end else if (front_r < FRONT_MAX) begin
            front_nxt = front_r + FW'(1);
          end
        end else begin
          tick_nxt = tick_sum[TW-1:0];
        end
        out_busy_nxt = running_nxt;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      front_r     <= '0;
      tick_r      <= '0;
      running_r   <= 1'b0;
      corner_r    <= 1'b0;
      target_r    <= ldfw_pkg::BLACK;
      k_r         <= '0;
      x_r         <= '0;
      y_r         <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      tick_r      <= tick_nxt;
      running_r   <= running_nxt;
      corner_r    <= corner_nxt;
      target_r    <= target_nxt;
      k_r         <= k_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpr_r <= ldfw_pkg::FPR_RESET;
    end else if (cfg_we) begin
      fpr_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    p_addr_r   <= k_r;
    p_lit_r    <= ((FW'(x_r) + FW'(y_r)) < front_r);
    p_corner_r <= (k_r == ADDR_LAST);
    rd_inr_r   <= in_range;
    out_col_r  <= out_col_nxt;
    out_busy_r <= out_busy_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_red      = out_col_r.red;
  assign out_green    = out_col_r.green;
  assign out_blue     = out_col_r.blue;
  assign out_busy_res = out_busy_r;
  assign out_finished = out_fin_r;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for led_matrix_diagonal_fade_wave: drives command
// items, predicts each readout in a scoreboard class and compares field by field.
// Depends on ldfw_pkg and the RTL of the block; reads no files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID = ldfw_pkg::GRID_DEFAULT;
  // Code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // No accepted item or readout for this many cycles ends the run
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]     cmd;
    ldfw_pkg::rgb_t target;
    logic [3:0]     read_x;
    logic [3:0]     read_y;
  } wave_item_t;

  typedef struct packed {
    ldfw_pkg::rgb_t colour;
    logic           busy_res;
    logic           finished;
  } wave_readout_t;

  // Predicts the wave state and holds the readouts still owed by the block
  class fade_wave_scoreboard;
    ldfw_pkg::rgb_t leds [GRID][GRID];
    ldfw_pkg::rgb_t target;
    int unsigned    front;
    int unsigned    ticks;
    bit             running;
    bit             corner_ok;
    logic [5:0]     frames_per_row;
    wave_readout_t  owed_readouts [$];
    int unsigned    errors;

    function new();
      foreach (leds[x, y]) leds[x][y] = ldfw_pkg::RESET_COLOUR;
      target = ldfw_pkg::BLACK;
      front = 0;
      ticks = 0;
      running = 0;
      corner_ok = 0;
      frames_per_row = ldfw_pkg::FPR_RESET;
      errors = 0;
    endfunction

    function logic [7:0] toward(logic [7:0] cur, logic [7:0] goal);
      if (cur < goal) return cur + 8'd1;
      if (cur > goal) return cur - 8'd1;
      return cur;
    endfunction

    // Apply one accepted item and queue the readout it owes
    function void note_item(wave_item_t it);
      wave_readout_t owed;
      int unsigned   limit;
      owed = '0;
      case (it.cmd)
        ldfw_pkg::CMD_START: begin
          if (!running) begin
            target = it.target;
            front = 1;
            ticks = 0;
            corner_ok = 0;
            running = 1;
          end
        end
        ldfw_pkg::CMD_TICK: begin
          if (running) begin
            foreach (leds[x, y]) begin
              if (x + y < front) begin
                leds[x][y] = '{red:   toward(leds[x][y].red, target.red),
                               green: toward(leds[x][y].green, target.green),
                               blue:  toward(leds[x][y].blue, target.blue)};
                if (x == GRID - 1 && y == GRID - 1) corner_ok = (leds[x][y] == target);
              end
            end
            // zero frames per row behaves as one
            limit = (frames_per_row == 0) ? 1 : frames_per_row;
            ticks++;
            if (ticks >= limit) begin
              ticks = 0;
              if (corner_ok) begin
                running = 0;
                owed.finished = 1'b1;
              end else if (front < 2 * GRID) begin
                front++;
              end
            end
          end
        end
        ldfw_pkg::CMD_READ: begin
          // outside the grid reads as black
          if (it.read_x < GRID && it.read_y < GRID) owed.colour = leds[it.read_x][it.read_y];
        end
        default: ;
      endcase
      owed.busy_res = running;
      owed_readouts.push_back(owed);
    endfunction

    // Compare one readout against the oldest owed one
    function void check_readout(wave_readout_t got);
      wave_readout_t owed;
      if (owed_readouts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected readout: rgb %06h busy %0b fin %0b",
                   got.colour, got.busy_res, got.finished);
        return;
      end
      owed = owed_readouts.pop_front();
      if (got.colour.red !== owed.colour.red || got.colour.green !== owed.colour.green ||
          got.colour.blue !== owed.colour.blue || got.busy_res !== owed.busy_res ||
          got.finished !== owed.finished) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp rgb %06h busy %0b fin %0b, got rgb %06h busy %0b fin %0b",
                   owed.colour, owed.busy_res, owed.finished,
                   got.colour, got.busy_res, got.finished);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 in_command = '0;
  logic [7:0]                 in_target_red = '0;
  logic [7:0]                 in_target_green = '0;
  logic [7:0]                 in_target_blue = '0;
  logic [3:0]                 in_read_x = '0;
  logic [3:0]                 in_read_y = '0;
  logic                       out_valid;
  logic [7:0]                 out_red;
  logic [7:0]                 out_green;
  logic [7:0]                 out_blue;
  logic                       out_busy_res;
  logic                       out_finished;
  logic                       cfg_we = 1'b0;
  logic [ldfw_pkg::FPR_W-1:0] cfg_data = '0;

  fade_wave_scoreboard sb = new();
  bit                  no_gaps = 0;
  int                  quiet_cycles = 0;

  led_matrix_diagonal_fade_wave #(.GRID(GRID)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_target_red   (in_target_red),
    .in_target_green (in_target_green),
    .in_target_blue  (in_target_blue),
    .in_read_x       (in_read_x),
    .in_read_y       (in_read_y),
    .out_valid       (out_valid),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_busy_res    (out_busy_res),
    .out_finished    (out_finished),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Readout monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_readout({out_red, out_green, out_blue, out_busy_res, out_finished});
  end

  // Watchdog: cycles with no accepted item and no readout
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  function automatic wave_item_t item_of(logic [1:0] cmd, ldfw_pkg::rgb_t tgt, int x, int y);
    item_of = '{cmd: cmd, target: tgt, read_x: 4'(x), read_y: 4'(y)};
  endfunction

  // Does the item change or read anything
  function automatic bit has_effect(wave_item_t it);
    case (it.cmd)
      ldfw_pkg::CMD_READ:  return 1;
      ldfw_pkg::CMD_START: return !sb.running;
      ldfw_pkg::CMD_TICK:  return sb.running;
      default:             return 0;
    endcase
  endfunction

  // Mostly well-formed waves: start, then ticks with reads; some noise
  function automatic wave_item_t next_item();
    wave_item_t     it;
    int             roll;
    int             v;
    ldfw_pkg::rgb_t corner;
    it = wave_item_t'({$urandom, $urandom});
    roll = $urandom_range(0, 99);
    corner = sb.leds[GRID-1][GRID-1];
    if (!sb.running) begin
      if (roll < 55) begin
        it.cmd = ldfw_pkg::CMD_START;
        // target near the far corner so most waves finish quickly
        if ($urandom_range(0, 99) < 80) begin
          for (int ch = 0; ch < 3; ch++) begin
            v = int'(corner[ch*8 +: 8]) + $urandom_range(0, 12) - 6;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            it.target[ch*8 +: 8] = 8'(v);
          end
        end
      end else if (roll < 80) it.cmd = ldfw_pkg::CMD_READ;
      else if (roll < 90) it.cmd = ldfw_pkg::CMD_TICK;
      else it.cmd = CMD_UNUSED;
    end else begin
      if (roll < 80) it.cmd = ldfw_pkg::CMD_TICK;
      else if (roll < 92) it.cmd = ldfw_pkg::CMD_READ;
      else if (roll < 96) it.cmd = ldfw_pkg::CMD_START;
      else it.cmd = CMD_UNUSED;
    end
    // reads mostly inside the grid
    if (it.cmd == ldfw_pkg::CMD_READ && $urandom_range(0, 9) != 0) begin
      it.read_x = 4'($urandom_range(0, GRID - 1));
      it.read_y = 4'($urandom_range(0, GRID - 1));
    end
    return it;
  endfunction

  // Present one item and wait until it is taken
  task automatic send_item(wave_item_t it);
    if (!no_gaps && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= it.cmd;
    in_target_red   <= it.target.red;
    in_target_green <= it.target.green;
    in_target_blue  <= it.target.blue;
    in_read_x       <= it.read_x;
    in_read_y       <= it.read_y;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
  endtask

  // Stop issuing and wait for every owed readout
  task automatic drain();
    start <= 1'b0;
    while (sb.owed_readouts.size() != 0) @(posedge clk);
  endtask

  task automatic write_fpr(logic [5:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.frames_per_row = value;
  endtask

  initial begin
    wave_item_t opening [$];
    int         fpr_plan [10];
    int         count_plan [10];
    int         done;
    wave_item_t it;

    fpr_plan   = '{-1, 63, 1, 0, 2, 1, 3, 63, 1, 5};
    count_plan = '{55, 80, 120, 110, 100, 115, 80, 35, 100, 45};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: grid corners, outside reads, ignored codes, a wave
    opening.push_back(item_of(ldfw_pkg::CMD_READ, ldfw_pkg::BLACK, 0, 0));
    opening.push_back(item_of(ldfw_pkg::CMD_READ, ldfw_pkg::BLACK, GRID - 1, GRID - 1));
    opening.push_back(item_of(ldfw_pkg::CMD_READ, ldfw_pkg::BLACK, 15, 15));
    opening.push_back(item_of(ldfw_pkg::CMD_READ, ldfw_pkg::BLACK, GRID, 3));
    opening.push_back(item_of(ldfw_pkg::CMD_READ, ldfw_pkg::BLACK, 3, GRID));
    opening.push_back(item_of(CMD_UNUSED, '1, 15, 15));
    opening.push_back(item_of(ldfw_pkg::CMD_TICK, ldfw_pkg::BLACK, 0, 0));
    opening.push_back(item_of(ldfw_pkg::CMD_START, ldfw_pkg::BLACK, 0, 0));
    opening.push_back(item_of(ldfw_pkg::CMD_START, '1, 0, 0));
    repeat (4) opening.push_back(item_of(ldfw_pkg::CMD_TICK, '1, 0, 0));
    opening.push_back(item_of(ldfw_pkg::CMD_READ, ldfw_pkg::BLACK, 0, 0));
    opening.push_back(item_of(ldfw_pkg::CMD_READ, ldfw_pkg::BLACK, 1, 0));
    opening.push_back(item_of(CMD_UNUSED, ldfw_pkg::BLACK, 0, 0));
    foreach (opening[i]) send_item(opening[i]);
    drain();

    // Random phases, each at one frames-per-row setting
    for (int p = 0; p < 10; p++) begin
      if (fpr_plan[p] >= 0) write_fpr(6'(fpr_plan[p]));
      no_gaps = (p == 3);
      done = 0;
      while (done < count_plan[p]) begin
        it = next_item();
        if (has_effect(it)) done++;
        send_item(it);
      end
      drain();
    end

    repeat (150) @(posedge clk);
    if (sb.errors == 0 && sb.owed_readouts.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ldfw_pkg.sv
rtl/core/ldfw_step.sv
rtl/core/led_matrix_diagonal_fade_wave.sv
verif/testbench.sv
